// ===== design/lfm_pkg.sv =====
`timescale 1ns / 1ps

package lfm_pkg;

  // Sample and state formats.
  localparam int SAMPLE_BITS      = 16;
  localparam int STATE_BITS       = 24;
  localparam int SFRAC            = STATE_BITS - 4;
  localparam int IFRAC            = SAMPLE_BITS - 1;
  localparam int IN_SHIFT         = SFRAC - IFRAC;
  localparam int GAIN_BITS        = 15;
  localparam int COEF_FRAC        = 14;
  localparam int COEF_W           = GAIN_BITS + 1;

  // Datapath widths.
  localparam int TMP_W            = STATE_BITS + 1;
  localparam int PROD_W           = TMP_W + COEF_W;
  localparam int RND_W            = PROD_W - COEF_FRAC;
  localparam int YS_W             = RND_W + 1;
  localparam int U_W              = STATE_BITS + 5;
  localparam int MIX_W            = STATE_BITS + 5;

  // Ladder stage coefficients b = 1/1.3 and c = 0.3/1.3 in Q1.14.
  localparam logic signed [COEF_W-1:0] COEF_B = COEF_W'(12603);
  localparam logic signed [COEF_W-1:0] COEF_C = COEF_W'(3781);

  // Soft clipper lookup.
  localparam int TANH_TABLE_DEPTH = 1024;
  localparam int TANH_IDX_W       = $clog2(TANH_TABLE_DEPTH);
  localparam int TANH_SHIFT       = SFRAC + 2 - TANH_IDX_W;
  localparam int TANH_W           = 17;
  localparam int TANH_UP          = SFRAC - 16;
  localparam int TANH_QUOT_W      = TANH_W + 1;
  localparam logic [TANH_W-1:0] TANH_ONE = TANH_W'(1 << 16);
  localparam logic [U_W-1:0]    TANH_SAT = U_W'(3 << SFRAC);

  // Mode register bits.
  localparam int MODE_HIGH_BIT     = 0;
  localparam int MODE_TWO_POLE_BIT = 1;

  localparam logic [1:0] STAGE_LAST_4P = 2'd3;
  localparam logic [1:0] STAGE_LAST_2P = 2'd1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_COMP,
    OP_DIFF,
    OP_FB,
    OP_USUM,
    OP_LUT,
    OP_TANH,
    OP_MB,
    OP_MC,
    OP_VSUM,
    OP_MG,
    OP_YUPD,
    OP_MIX,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] stage;
  } cmd_t;

  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_TABLE_DEPTH];

  // Restoring shift-and-subtract division for the table build; the quotient
  // of every table entry stays below 2^TANH_QUOT_W.
  function automatic longint tanh_div(input longint num, input longint den);
    longint rem;
    longint quo;
    rem = num;
    quo = 0;
    for (int k = TANH_QUOT_W - 1; k >= 0; k--) begin
      if (rem >= (den <<< k)) begin
        rem = rem - (den <<< k);
        quo = quo | (longint'(1) <<< k);
      end
    end
    return quo;
  endfunction

  // Pade form x(27+x^2)/(27+9x^2) in Q16, floored, on a grid of 4/depth.
  function automatic tanh_rom_t tanh_rom_init();
    tanh_rom_t rom;
    longint x;
    longint x2;
    longint s2;
    longint y;
    s2 = longint'(27) <<< 32;
    for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
      x = longint'(i) <<< (18 - TANH_IDX_W);
      x2 = x * x;
      y = tanh_div(x * (s2 + x2), s2 + 9 * x2);
      rom[i] = TANH_W'(y);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = tanh_rom_init();

  // Drop the Q14 coefficient fraction, rounding ties toward plus infinity.
  function automatic logic signed [RND_W-1:0] round_coef(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] s;
    s = v + PROD_W'(1 << (COEF_FRAC - 1));
    return s[PROD_W-1:COEF_FRAC];
  endfunction

endpackage

// ===== design/lfm_ctrl.sv =====
`timescale 1ns / 1ps

module lfm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  input  logic          two_pole_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output lfm_pkg::cmd_t cmd_o
);
  import lfm_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_COMP = 4'd1;
  localparam logic [3:0] ST_DIFF = 4'd2;
  localparam logic [3:0] ST_FB   = 4'd3;
  localparam logic [3:0] ST_USUM = 4'd4;
  localparam logic [3:0] ST_LUT  = 4'd5;
  localparam logic [3:0] ST_TANH = 4'd6;
  localparam logic [3:0] ST_MB   = 4'd7;
  localparam logic [3:0] ST_MC   = 4'd8;
  localparam logic [3:0] ST_VSUM = 4'd9;
  localparam logic [3:0] ST_MG   = 4'd10;
  localparam logic [3:0] ST_YUPD = 4'd11;
  localparam logic [3:0] ST_MIX  = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] stage_q, stage_d;
  logic       out_valid_q, out_valid_d;
  logic       out_load;
  logic [1:0] last_stage;

  assign last_stage = two_pole_i ? STAGE_LAST_2P : STAGE_LAST_4P;

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    out_load    = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.stage = stage_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd_o.op = OP_COMP;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        // Feedback is taken from the last active stage.
        cmd_o.op    = OP_DIFF;
        cmd_o.stage = last_stage;
        state_d     = ST_FB;
      end
      ST_FB: begin
        cmd_o.op = OP_FB;
        state_d  = ST_USUM;
      end
      ST_USUM: begin
        cmd_o.op = OP_USUM;
        state_d  = ST_LUT;
      end
      ST_LUT: begin
        cmd_o.op = OP_LUT;
        state_d  = ST_TANH;
      end
      ST_TANH: begin
        cmd_o.op = OP_TANH;
        stage_d  = 2'd0;
        state_d  = ST_MB;
      end
      ST_MB: begin
        cmd_o.op = OP_MB;
        state_d  = ST_MC;
      end
      ST_MC: begin
        cmd_o.op = OP_MC;
        state_d  = ST_VSUM;
      end
      ST_VSUM: begin
        cmd_o.op = OP_VSUM;
        state_d  = ST_MG;
      end
      ST_MG: begin
        cmd_o.op = OP_MG;
        state_d  = ST_YUPD;
      end
      ST_YUPD: begin
        cmd_o.op = OP_YUPD;
        if (stage_q == last_stage) begin
          state_d = ST_MIX;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = ST_MB;
        end
      end
      ST_MIX: begin
        cmd_o.op = OP_MIX;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // Wait here only while the previous result is still held.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/lfm_dp.sv =====
`timescale 1ns / 1ps

module lfm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfm_pkg::cmd_t                       cmd_i,
  input  logic [1:0]                          filter_mode_i,
  input  logic [lfm_pkg::GAIN_BITS-1:0]       cutoff_gain_i,
  input  logic [lfm_pkg::GAIN_BITS-1:0]       resonance_gain_i,
  input  logic [lfm_pkg::GAIN_BITS-1:0]       comp_gain_i,
  input  logic signed [lfm_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic signed [lfm_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import lfm_pkg::*;

  logic signed [STATE_BITS-1:0]  x_q, cur_q, t_q;
  logic signed [TMP_W-1:0]       tmp_q;
  logic signed [PROD_W-1:0]      prod_q, acc_q;
  logic signed [U_W-1:0]         u_q;
  logic [TANH_W-1:0]             rom_q;
  logic                          neg_q, big_q;
  logic signed [MIX_W-1:0]       mix_q;
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic signed [STATE_BITS-1:0]  prev_q [4];
  logic signed [STATE_BITS-1:0]  y_q [4];

  logic signed [TMP_W-1:0]       mul_a;
  logic signed [COEF_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [RND_W-1:0]       prod_rnd, v_rnd;
  logic signed [STATE_BITS-1:0]  y_sel;
  logic signed [TMP_W-1:0]       diff_d, vdiff_d;
  logic signed [U_W-1:0]         u_d, u_abs;
  logic                          big_d;
  logic [TANH_IDX_W-1:0]         lut_idx;
  logic [TANH_W-1:0]             mag;
  logic signed [STATE_BITS-1:0]  t_mag, t_val;
  logic signed [YS_W-1:0]        ysum;
  logic signed [STATE_BITS-1:0]  ny;
  logic signed [MIX_W-1:0]       m0, m1, m2, m3, mt, mix_d, mix_rnd;
  logic signed [SAMPLE_BITS-1:0] out_d;

  // Shared multiplier; its product is always registered in prod_q.
  always_comb begin
    unique case (cmd_i.op)
      OP_COMP: begin
        mul_a = TMP_W'(x_q);
        mul_b = signed'({1'b0, comp_gain_i});
      end
      OP_FB: begin
        mul_a = tmp_q;
        mul_b = signed'({1'b0, resonance_gain_i});
      end
      OP_MB: begin
        mul_a = TMP_W'(cur_q);
        mul_b = COEF_B;
      end
      OP_MC: begin
        mul_a = TMP_W'(prev_q[cmd_i.stage]);
        mul_b = COEF_C;
      end
      OP_MG: begin
        mul_a = tmp_q;
        mul_b = signed'({1'b0, cutoff_gain_i});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_rnd = round_coef(prod_q);
  assign v_rnd    = round_coef(acc_q + prod_q);
  assign y_sel    = y_q[cmd_i.stage];

  assign diff_d  = TMP_W'(RND_W'(y_sel) - prod_rnd);
  assign vdiff_d = TMP_W'(v_rnd - RND_W'(y_sel));
  assign u_d     = U_W'(x_q) - (U_W'(prod_rnd) <<< 2);

  // Magnitude of the clipper input; at three and above the output is exactly one.
  assign u_abs   = u_q[U_W-1] ? -u_q : u_q;
  assign big_d   = (u_abs >= signed'(TANH_SAT));
  assign lut_idx = u_abs[TANH_SHIFT +: TANH_IDX_W];

  assign mag   = big_q ? TANH_ONE : rom_q;
  assign t_mag = signed'(STATE_BITS'(mag) << TANH_UP);
  assign t_val = neg_q ? -t_mag : t_mag;

  assign ysum = YS_W'(y_sel) + YS_W'(prod_rnd);

  always_comb begin
    if (ysum[YS_W-1:STATE_BITS-1] == '0 || ysum[YS_W-1:STATE_BITS-1] == '1) begin
      ny = ysum[STATE_BITS-1:0];
    end else if (ysum[YS_W-1]) begin
      ny = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      ny = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  end

  assign m0 = MIX_W'(y_q[0]);
  assign m1 = MIX_W'(y_q[1]);
  assign m2 = MIX_W'(y_q[2]);
  assign m3 = MIX_W'(y_q[3]);
  assign mt = MIX_W'(t_q);

  // Highpass uses binomial weights over the clipped input and stage outputs.
  always_comb begin
    if (!filter_mode_i[MODE_TWO_POLE_BIT]) begin
      if (filter_mode_i[MODE_HIGH_BIT]) begin
        mix_d = mt - (m0 <<< 2) + (m1 <<< 2) + (m1 <<< 1) - (m2 <<< 2) + m3;
      end else begin
        mix_d = m3;
      end
    end else begin
      if (filter_mode_i[MODE_HIGH_BIT]) begin
        mix_d = mt - (m0 <<< 1) + m1;
      end else begin
        mix_d = m1;
      end
    end
  end

  assign mix_rnd = (mix_q + MIX_W'(1 << (IN_SHIFT - 1))) >>> IN_SHIFT;

  always_comb begin
    if (mix_rnd[MIX_W-1:SAMPLE_BITS-1] == '0 || mix_rnd[MIX_W-1:SAMPLE_BITS-1] == '1) begin
      out_d = mix_rnd[SAMPLE_BITS-1:0];
    end else if (mix_rnd[MIX_W-1]) begin
      out_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      out_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op) inside
      OP_LOAD: x_q <= STATE_BITS'(sample_in_i) <<< IN_SHIFT;
      OP_COMP, OP_FB, OP_MB, OP_MG: prod_q <= mul_p;
      OP_MC: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      OP_DIFF: tmp_q <= diff_d;
      OP_USUM: u_q <= u_d;
      OP_LUT: begin
        rom_q <= TANH_ROM[lut_idx];
        neg_q <= u_q[U_W-1];
        big_q <= big_d;
      end
      OP_TANH: begin
        t_q   <= t_val;
        cur_q <= t_val;
      end
      OP_VSUM: tmp_q <= vdiff_d;
      OP_YUPD: cur_q <= ny;
      OP_MIX: mix_q <= mix_d;
      OP_OUT: out_q <= out_d;
      default: begin
      end
    endcase
  end

  // Filter state: each stage keeps its last input and its last output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        prev_q[i] <= '0;
        y_q[i]    <= '0;
      end
    end else if (cmd_i.op == OP_YUPD) begin
      prev_q[cmd_i.stage] <= cur_q;
      y_q[cmd_i.stage]    <= ny;
    end
  end

  assign sample_out_o = out_q;

endmodule

// ===== design/ladder_filter_four_mode.sv =====
`timescale 1ns / 1ps

// Resonant ladder filter with four modes: four-pole or two-pole, lowpass or highpass.
// Samples enter on the in_valid_i / in_ready_o channel and results leave on the
// out_valid_o / out_ready_i channel, one result for each request. A request is
// taken when valid and ready are both high at a rising clock edge.
// The four settings are written through cfg_we_i, cfg_idx_i and cfg_data_i:
// index 0 mode, 1 cutoff gain, 2 resonance gain, 3 input compensation gain.
// The user must write them only while the filter is idle; the block itself
// does not enforce this. A new request is taken only after the previous result
// has been written to the output register. The schedule is set by the single
// shared multiplier: six steps for feedback and soft clipping, five steps
// per ladder stage run one after another, and two for mixing and output.
// Reset restores the default settings and clears all stage state; no result is
// pending afterwards. If the receiver stalls, the finished result waits in the
// output register and the next request is still accepted and computed; that one
// then waits for the output register to drain before it is written.
module ladder_filter_four_mode (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_idx_i,
  input  logic [lfm_pkg::GAIN_BITS-1:0]          cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [lfm_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lfm_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import lfm_pkg::*;

  localparam logic [1:0] REG_FILTER_MODE    = 2'd0;
  localparam logic [1:0] REG_CUTOFF_GAIN    = 2'd1;
  localparam logic [1:0] REG_RESONANCE_GAIN = 2'd2;
  localparam logic [1:0] REG_COMP_GAIN      = 2'd3;

  logic [1:0]           filter_mode_q;
  logic [GAIN_BITS-1:0] cutoff_gain_q;
  logic [GAIN_BITS-1:0] resonance_gain_q;
  logic [GAIN_BITS-1:0] comp_gain_q;
  cmd_t                 cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q    <= 2'd0;
      cutoff_gain_q    <= GAIN_BITS'(4096);
      resonance_gain_q <= '0;
      comp_gain_q      <= GAIN_BITS'(8192);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILTER_MODE:    filter_mode_q    <= cfg_data_i[1:0];
        REG_CUTOFF_GAIN:    cutoff_gain_q    <= cfg_data_i;
        REG_RESONANCE_GAIN: resonance_gain_q <= cfg_data_i;
        REG_COMP_GAIN:      comp_gain_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .two_pole_i  (filter_mode_q[MODE_TWO_POLE_BIT]),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  lfm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .filter_mode_i    (filter_mode_q),
    .cutoff_gain_i    (cutoff_gain_q),
    .resonance_gain_i (resonance_gain_q),
    .comp_gain_i      (comp_gain_q),
    .sample_in_i      (sample_in_i),
    .sample_out_o     (sample_out_o)
  );

  // Once a request is taken, the block is busy until its result is written.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after a request");

  // A result is written only into a free output register.
  a_out_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_OUT) |-> (!out_valid_o || out_ready_i))
    else $error("result written over a pending result");

  // Output valid rises only from an output write.
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op == OP_OUT))
    else $error("output valid rose without a result write");

endmodule
